// ===== src/wmfp_pkg.sv =====
// shared types, constants and helpers of the weighted min-max fair picker
`default_nettype none

package wmfp_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int STREAM_COUNT = 8;
  localparam int REG_COUNT    = 8;

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int STRM_W    = 3;
  localparam int TAG_W     = 16;
  localparam int WGT_W     = 8;
  localparam int SVC_W     = 32;
  localparam int NUM_W     = SVC_W + 1;
  localparam int PROD_W    = NUM_W + WGT_W;
  localparam int OCC_W     = 5;
  localparam int CFG_IDX_W = 4;
  localparam int WIDX_W    = $clog2(REG_COUNT);

  localparam logic KIND_ENQ  = 1'b0;
  localparam logic KIND_PICK = 1'b1;

  typedef enum logic [1:0] {
    STS_ENQ   = 2'd0,
    STS_PICK  = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic scan_read;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_pick;
    logic full;
    logic empty;
    logic scan_last;
  } sts_t;

  // a zero weight counts as one
  function automatic logic [WGT_W-1:0] eff_weight(input logic [WGT_W-1:0] w);
    return (w == '0) ? WGT_W'(1) : w;
  endfunction

endpackage

`default_nettype wire

// ===== src/weighted_minmax_fair_picker_core.sv =====
// top level of the weighted min-max fair picker
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    in_kind, in_stream_num, in_txn_tag
//  out_     output     out_valid / out_ready  out_status, out_picked_stream,
//                                             out_picked_tag, out_occupancy
//  cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  enqueue, empty pick and full drop: decode, then the result state loads the
//  output register; pick of n queued items: one entry per cycle through the
//  cross-multiply comparator, then a drain step, a commit and the result state
//  reset: synchronous active low; weights 1, service counts 0, queue empty
//  a new item is taken while a result waits in the output register; its own
//  result holds until that register is free
`default_nettype none

module weighted_minmax_fair_picker_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_kind,
  input  wire logic [wmfp_pkg::STRM_W-1:0]     in_stream_num,
  input  wire logic [wmfp_pkg::TAG_W-1:0]      in_txn_tag,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_status,
  output logic [wmfp_pkg::STRM_W-1:0]          out_picked_stream,
  output logic [wmfp_pkg::TAG_W-1:0]           out_picked_tag,
  output logic [wmfp_pkg::OCC_W-1:0]           out_occupancy,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wmfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wmfp_pkg::WGT_W-1:0]      cfg_data
);
  import wmfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  wmfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  wmfp_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_stream_num     (in_stream_num),
    .in_txn_tag        (in_txn_tag),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_status        (out_status),
    .out_picked_stream (out_picked_stream),
    .out_picked_tag    (out_picked_tag),
    .out_occupancy     (out_occupancy)
  );

endmodule

`default_nettype wire

// ===== src/wmfp_datapath.sv =====
// queue storage, service counts, weights, scan comparator and result registers
`default_nettype none

module wmfp_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire wmfp_pkg::cmd_t                  cmd,
  output wmfp_pkg::sts_t                       sts,
  input  wire logic                            in_kind,
  input  wire logic [wmfp_pkg::STRM_W-1:0]     in_stream_num,
  input  wire logic [wmfp_pkg::TAG_W-1:0]      in_txn_tag,
  input  wire logic                            cfg_we,
  input  wire logic [wmfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wmfp_pkg::WGT_W-1:0]      cfg_data,
  output logic [1:0]                           out_status,
  output logic [wmfp_pkg::STRM_W-1:0]          out_picked_stream,
  output logic [wmfp_pkg::TAG_W-1:0]           out_picked_tag,
  output logic [wmfp_pkg::OCC_W-1:0]           out_occupancy
);
  import wmfp_pkg::*;

  logic              in_kind_r;
  logic [STRM_W-1:0] in_stream_r;
  logic [TAG_W-1:0]  in_tag_r;

  logic [STRM_W-1:0] slot_stream_r [QUEUE_DEPTH];
  logic [TAG_W-1:0]  slot_tag_r    [QUEUE_DEPTH];
  logic [CNT_W-1:0]  fill_r;
  logic [SVC_W-1:0]  served_r      [STREAM_COUNT];
  logic [WGT_W-1:0]  weight_r      [REG_COUNT];

  logic [IDX_W-1:0]  scan_idx_r;

  logic              cur_vld_r;
  logic [IDX_W-1:0]  cur_idx_r;
  logic [STRM_W-1:0] cur_stream_r;
  logic [TAG_W-1:0]  cur_tag_r;
  logic [NUM_W-1:0]  cur_num_r;
  logic [WGT_W-1:0]  cur_w_r;

  logic [IDX_W-1:0]  best_idx_r;
  logic [STRM_W-1:0] best_stream_r;
  logic [TAG_W-1:0]  best_tag_r;
  logic [NUM_W-1:0]  best_num_r;
  logic [WGT_W-1:0]  best_w_r;

  status_t           res_status_r;
  logic [STRM_W-1:0] res_stream_r;
  logic [TAG_W-1:0]  res_tag_r;

  status_t           out_status_r;
  logic [STRM_W-1:0] out_stream_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic [STRM_W-1:0] rd_stream;
  logic [NUM_W-1:0]  rd_num;
  logic [WGT_W-1:0]  rd_w;
  logic [PROD_W-1:0] prod_cur;
  logic [PROD_W-1:0] prod_best;
  logic              take;
  logic              do_enq;
  logic [STRM_W-1:0] enq_stream;

  assign sts.is_pick   = (in_kind_r == KIND_PICK);
  assign sts.full      = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign sts.empty     = (fill_r == '0);
  assign sts.scan_last = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == fill_r);

  assign do_enq     = cmd.decode && !sts.is_pick && !sts.full;
  assign enq_stream = STRM_W'(in_stream_r % STREAM_COUNT);

  // read stage of the scan
  assign rd_stream = slot_stream_r[scan_idx_r];
  assign rd_num    = {1'b0, served_r[rd_stream]} + NUM_W'(1);
  assign rd_w      = eff_weight(weight_r[rd_stream]);

  // compare stage: (cur+1)*w_best < (best+1)*w_cur
  assign prod_cur  = PROD_W'(cur_num_r) * PROD_W'(best_w_r);
  assign prod_best = PROD_W'(best_num_r) * PROD_W'(cur_w_r);
  assign take      = cur_vld_r && ((cur_idx_r == '0) || (prod_cur < prod_best));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      cur_vld_r <= 1'b0;
      for (int i = 0; i < STREAM_COUNT; i++) begin
        served_r[i] <= '0;
      end
      for (int i = 0; i < REG_COUNT; i++) begin
        weight_r[i] <= WGT_W'(1);
      end
    end else begin
      cur_vld_r <= cmd.scan_read;
      if (cfg_we && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
        weight_r[cfg_index[WIDX_W-1:0]] <= cfg_data;
      end
      if (do_enq) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (cmd.commit) begin
        fill_r <= fill_r - CNT_W'(1);
        served_r[best_stream_r] <= best_num_r[SVC_W] ? '1 : best_num_r[SVC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_kind_r   <= in_kind;
      in_stream_r <= in_stream_num;
      in_tag_r    <= in_txn_tag;
    end

    if (do_enq) begin
      slot_stream_r[IDX_W'(fill_r)] <= enq_stream;
      slot_tag_r[IDX_W'(fill_r)]    <= in_tag_r;
    end else if (cmd.commit) begin
      // close the gap left by the picked item
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (IDX_W'(i) >= best_idx_r) begin
          slot_stream_r[i] <= slot_stream_r[i+1];
          slot_tag_r[i]    <= slot_tag_r[i+1];
        end
      end
    end

    if (cmd.decode) begin
      scan_idx_r   <= '0;
      res_stream_r <= '0;
      res_tag_r    <= '0;
      if (!sts.is_pick) begin
        res_status_r <= sts.full ? STS_FULL : STS_ENQ;
      end else begin
        res_status_r <= STS_EMPTY;
      end
    end else if (cmd.scan_read) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end

    if (cmd.scan_read) begin
      cur_idx_r    <= scan_idx_r;
      cur_stream_r <= rd_stream;
      cur_tag_r    <= slot_tag_r[scan_idx_r];
      cur_num_r    <= rd_num;
      cur_w_r      <= rd_w;
    end

    if (take) begin
      best_idx_r    <= cur_idx_r;
      best_stream_r <= cur_stream_r;
      best_tag_r    <= cur_tag_r;
      best_num_r    <= cur_num_r;
      best_w_r      <= cur_w_r;
    end

    if (cmd.commit) begin
      res_status_r <= STS_PICK;
      res_stream_r <= best_stream_r;
      res_tag_r    <= best_tag_r;
    end

    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_stream_r <= res_stream_r;
      out_tag_r    <= res_tag_r;
      out_occ_r    <= OCC_W'(fill_r);
    end
  end

  assign out_status        = out_status_r;
  assign out_picked_stream = out_stream_r;
  assign out_picked_tag    = out_tag_r;
  assign out_occupancy     = out_occ_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (CNT_W'(cur_idx_r) < fill_r))
    else $error("scan compares an entry beyond the fill");

  a_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (fill_r != '0) && !cur_vld_r)
    else $error("pick committed before the scan finished or on an empty queue");

endmodule

`default_nettype wire

// ===== src/wmfp_ctrl.sv =====
// controller state machine sequencing decode, scan, commit and result hand-off
`default_nettype none

module wmfp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output wmfp_pkg::cmd_t      cmd,
  input  wire wmfp_pkg::sts_t sts
);
  import wmfp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = (sts.is_pick && !sts.empty) ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        cmd.scan_read = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted item not decoded next");

  a_scan_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !sts.scan_last) |=> (state_r == ST_SCAN))
    else $error("scan left before the last entry");

  a_drain_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> cmd.commit)
    else $error("last compare not followed by commit");

endmodule

`default_nettype wire

// ===== test/weighted_minmax_fair_picker_core_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for the weighted min-max fair picker: model-based scoreboard, phased traffic
module weighted_minmax_fair_picker_core_test;
  import wmfp_pkg::*;

  typedef struct {
    logic              kind;
    logic [STRM_W-1:0] stream;
    logic [TAG_W-1:0]  tag;
  } txn_item_t;

  typedef struct {
    logic [STRM_W-1:0] stream;
    logic [TAG_W-1:0]  tag;
  } queued_txn_t;

  typedef struct {
    status_t           status;
    logic [STRM_W-1:0] stream;
    logic [TAG_W-1:0]  tag;
    logic [OCC_W-1:0]  occ;
  } pick_outcome_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = KIND_ENQ;
  logic [STRM_W-1:0]    in_stream_num = '0;
  logic [TAG_W-1:0]     in_txn_tag = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_status;
  logic [STRM_W-1:0]    out_picked_stream;
  logic [TAG_W-1:0]     out_picked_tag;
  logic [OCC_W-1:0]     out_occupancy;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WGT_W-1:0]     cfg_data = '0;

  // predictor state
  logic [WGT_W-1:0] model_weight [REG_COUNT];
  logic [SVC_W-1:0] model_served [STREAM_COUNT];
  queued_txn_t      model_queue [$];

  txn_item_t     pending_txns [$];
  pick_outcome_t due_outcomes [$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_len = 0;
  int holdoff_req = 0;
  int holdoff_ack = 0;
  int holdoff_left = 0;
  int error_count = 0;

  weighted_minmax_fair_picker_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_stream_num     (in_stream_num),
    .in_txn_tag        (in_txn_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_picked_stream (out_picked_stream),
    .out_picked_tag    (out_picked_tag),
    .out_occupancy     (out_occupancy),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] share_weight(input logic [STRM_W-1:0] s);
    return (model_weight[s] == '0) ? 64'd1 : 64'(model_weight[s]);
  endfunction

  function automatic logic [63:0] share_need(input logic [STRM_W-1:0] s);
    return 64'(model_served[s]) + 64'd1;
  endfunction

  // applies one item to the predictor and returns the outcome it must produce
  function automatic pick_outcome_t arbitrate_txn(input txn_item_t it);
    pick_outcome_t r;
    queued_txn_t   e;
    int            best;
    logic [63:0]   best_need;
    logic [63:0]   best_w;
    logic [63:0]   cand_need;
    logic [63:0]   cand_w;
    logic [STRM_W-1:0] s;
    r.status = STS_ENQ;
    r.stream = '0;
    r.tag = '0;
    if (it.kind == KIND_ENQ) begin
      if (model_queue.size() >= QUEUE_DEPTH) begin
        r.status = STS_FULL;
      end else begin
        e.stream = it.stream;
        e.tag = it.tag;
        model_queue.insert(model_queue.size(), e);
      end
    end else if (model_queue.size() == 0) begin
      r.status = STS_EMPTY;
    end else begin
      best = 0;
      best_need = share_need(model_queue[0].stream);
      best_w = share_weight(model_queue[0].stream);
      for (int i = 1; i < model_queue.size(); i++) begin
        cand_need = share_need(model_queue[i].stream);
        cand_w = share_weight(model_queue[i].stream);
        if (cand_need * best_w < best_need * cand_w) begin
          best = i;
          best_need = cand_need;
          best_w = cand_w;
        end
      end
      s = model_queue[best].stream;
      r.status = STS_PICK;
      r.stream = s;
      r.tag = model_queue[best].tag;
      if (model_served[s] != '1) model_served[s] = model_served[s] + 1'b1;
      model_queue.delete(best);
    end
    r.occ = OCC_W'(model_queue.size());
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin : txn_driver
    txn_item_t sent;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sent = pending_txns.pop_front();
        due_outcomes.insert(due_outcomes.size(), arbitrate_txn(sent));
      end
      if (!in_valid || in_ready) begin
        if (pending_txns.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_kind <= pending_txns[0].kind;
          in_stream_num <= pending_txns[0].stream;
          in_txn_tag <= pending_txns[0].tag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    pick_outcome_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_outcomes.size() == 0) begin
          note_mismatch($sformatf("unexpected item: status %0d stream %0d tag %h occupancy %0d",
                                  out_status, out_picked_stream, out_picked_tag, out_occupancy));
        end else begin
          want = due_outcomes.pop_front();
          if (out_status !== want.status || out_picked_stream !== want.stream ||
              out_picked_tag !== want.tag || out_occupancy !== want.occ) begin
            note_mismatch($sformatf({"expected status %0d stream %0d tag %h occupancy %0d, ",
                                     "got status %0d stream %0d tag %h occupancy %0d"},
                                    want.status, want.stream, want.tag, want.occ,
                                    out_status, out_picked_stream, out_picked_tag,
                                    out_occupancy));
          end
        end
      end
      if (holdoff_ack != holdoff_req) begin
        holdoff_ack <= holdoff_req;
        holdoff_left <= holdoff_len;
        out_ready <= 1'b0;
      end else if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic add_txn(input logic kind, input int stream, input int tag);
    txn_item_t it;
    it.kind = kind;
    it.stream = STRM_W'(stream);
    it.tag = TAG_W'(tag);
    pending_txns.insert(pending_txns.size(), it);
  endtask

  // enqueue share swings between chunks so the queue runs both full and empty
  task automatic add_random_txns(input int count);
    int enq_pct;
    enq_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) enq_pct = 25 * $urandom_range(1, 3);
      add_txn(($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_PICK,
              $urandom_range(7), $urandom_range(16'hffff));
    end
  endtask

  task automatic wait_drained();
    while (pending_txns.size() != 0 || in_valid || due_outcomes.size() != 0) @(posedge clk);
  endtask

  // writes every weight; optionally also the unused indexes above them
  task automatic program_weights(input logic [REG_COUNT*WGT_W-1:0] flat, input bit with_unused);
    int last;
    last = with_unused ? (1 << CFG_IDX_W) : REG_COUNT;
    cfg_valid <= 1'b1;
    for (int r = 0; r < last; r++) begin
      cfg_index <= CFG_IDX_W'(r);
      cfg_data <= (r < REG_COUNT) ? flat[r*WGT_W +: WGT_W] : WGT_W'($urandom_range(255));
      do @(posedge clk); while (!cfg_ready);
      if (r < REG_COUNT) model_weight[r] = flat[r*WGT_W +: WGT_W];
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [REG_COUNT*WGT_W-1:0] wflat;
    for (int i = 0; i < REG_COUNT; i++) model_weight[i] = WGT_W'(1);
    for (int i = 0; i < STREAM_COUNT; i++) model_served[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pick, fill to the brim with tie weights, overflow, then drain half
    add_txn(KIND_PICK, 7, 16'hffff);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0: add_txn(KIND_ENQ, 0, 16'h0000);
        1: add_txn(KIND_ENQ, 1, 16'hffff);
        2: add_txn(KIND_ENQ, 2, 16'haaaa);
        3: add_txn(KIND_ENQ, 3, 16'h5555);
        default: add_txn(KIND_ENQ, (i < 8) ? i : 15 - i, i * 16'h1111);
      endcase
    end
    add_txn(KIND_ENQ, 3, 16'h1234);
    for (int i = 0; i < 8; i++) add_txn(KIND_PICK, $urandom_range(7), $urandom_range(16'hffff));
    wait_drained();

    add_random_txns(400);
    wait_drained();

    program_weights({REG_COUNT{8'd255}}, 1'b0);
    sender_idle_pct = 68;
    add_random_txns(400);
    wait_drained();

    // zero weight on stream 0, plus writes to the unused indexes
    program_weights({8'd17, 8'd2, 8'd255, 8'd3, 8'd128, 8'd1, 8'd255, 8'd0}, 1'b1);
    sender_idle_pct = 0;
    recv_stall_pct = 68;
    add_random_txns(400);
    wait_drained();

    for (int r = 0; r < REG_COUNT; r++) wflat[r*WGT_W +: WGT_W] = WGT_W'($urandom_range(1, 255));
    program_weights(wflat, 1'b0);
    sender_idle_pct = 11;
    recv_stall_pct = 11;
    add_random_txns(400);
    wait_drained();

    // long receiver hold-off with the sender pushing on
    program_weights({REG_COUNT{8'd1}}, 1'b0);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_len = 300;
    holdoff_req = holdoff_req + 1;
    add_random_txns(200);
    wait_drained();
    add_random_txns(200);
    wait_drained();

    repeat (40) @(posedge clk);
    if (error_count == 0 && due_outcomes.size() == 0) begin
      $display("weighted_minmax_fair_picker_core_test: clean");
    end else begin
      $display("weighted_minmax_fair_picker_core_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("weighted_minmax_fair_picker_core_test: errors");
    $finish;
  end

endmodule
